[hw/rtl/dfpf_pkg.sv]
package dfpf_pkg;

  // Upper limit on the digit count and on the fraction count.
  localparam int unsigned MAX_DIGITS = 10;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIV_W      = 30;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned STEPS      = DATA_W;
  localparam int unsigned STEP_W     = $clog2(STEPS);
  // A 32-bit value never has more than ten decimal digits.
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = BCD_DIGITS * 4;
  // Wide enough for MAX_DIGITS plus the decimal point.
  localparam int unsigned CNT_W      = 5;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] value;
    logic [LEN_W-1:0]  digit_count;
    logic [LEN_W-1:0]  frac_digits;
    logic [DIV_W-1:0]  point_divisor;
  } dfpf_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } dfpf_out_t;

  // Status of an iterative unit: busy while stepping, done for one cycle after.
  typedef struct packed {
    logic busy;
    logic done;
  } dfpf_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_CONVQ,
    ST_EMIT
  } dfpf_state_e;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_LEAD,
    MODE_SPLIT
  } dfpf_mode_e;

  // Adds three to every BCD digit of five or more (double-dabble correction).
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        res[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // Digit at a decimal position; positions beyond the word read as zero.
  function automatic logic [3:0] get_digit(input logic [BCD_W-1:0] bcd,
                                           input logic [CNT_W-1:0] pos);
    logic [3:0] d;
    d = 4'd0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (pos == CNT_W'(i)) begin
        d = bcd[i*4 +: 4];
      end
    end
    return d;
  endfunction

endpackage

[hw/rtl/decimal_fixed_point_formatter_top.sv]
// Prints one unsigned 32-bit value as a string of ASCII characters, most significant
// first, one item per character on the output channel, with last_char set on the final
// character. In plain mode (cmd 0) the low digit_count digits come out zero-padded. In
// fixed-point mode (cmd 1) a decimal point is placed so that frac_digits digits follow
// it: when digit_count is below frac_digits the output is the point, leading zeros and
// the digits; otherwise it is the integer digits of value / point_divisor, the point and
// the low fraction digits of value. A zero digit count counts as one, larger counts
// saturate at MAX_DIGITS, and a zero divisor gives an all-ones quotient. The block holds
// one item at a time: after an item is accepted, a restoring divider and a
// shift-and-add-three BCD converter run side by side, one bit per cycle, and then hand
// over. When integer digits of the quotient are printed the same converter runs a second
// pass on the quotient. Characters then leave at up to one per cycle through the output
// register while the receiver does not stall. No state is kept between items.
module decimal_fixed_point_formatter_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dfpf_pkg::dfpf_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dfpf_pkg::dfpf_out_t  out_data_o
);
  import dfpf_pkg::*;

  dfpf_state_e       state_q, state_d;
  dfpf_mode_e        mode_q, mode_c;
  logic [CNT_W-1:0]  len_q, len_c;
  logic [CNT_W-1:0]  frac_q, frac_c;
  logic [CNT_W-1:0]  ilen_q;
  logic [CNT_W-1:0]  total_q, total_c;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              need_q_q, need_q_c;
  logic [BCD_W-1:0]  vbcd_q;

  logic              accept;
  logic              emit_fire;
  logic              capture_v;
  logic              bcd_start;
  logic [DATA_W-1:0] bcd_bin;
  logic [BCD_W-1:0]  bcd_res;
  logic [DATA_W-1:0] quotient;
  dfpf_sts_t         div_sts;
  dfpf_sts_t         bcd_sts;

  logic              out_valid_q, out_valid_d;
  dfpf_out_t         out_data_q;
  dfpf_out_t         char_c;
  logic [CNT_W-1:0]  pos;
  logic [3:0]        digit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Normalize the counts and pick the layout of the string when the item arrives.
  always_comb begin
    if (in_data_i.digit_count == '0) begin
      len_c = CNT_W'(1);
    end else if ({1'b0, in_data_i.digit_count} > CNT_W'(MAX_DIGITS)) begin
      len_c = CNT_W'(MAX_DIGITS);
    end else begin
      len_c = CNT_W'(in_data_i.digit_count);
    end
    if ({1'b0, in_data_i.frac_digits} > CNT_W'(MAX_DIGITS)) begin
      frac_c = CNT_W'(MAX_DIGITS);
    end else begin
      frac_c = CNT_W'(in_data_i.frac_digits);
    end
    if (!in_data_i.cmd) begin
      mode_c  = MODE_PLAIN;
      total_c = len_c;
    end else if (len_c < frac_c) begin
      mode_c  = MODE_LEAD;
      total_c = frac_c + CNT_W'(1);
    end else begin
      mode_c  = MODE_SPLIT;
      total_c = len_c + CNT_W'(1);
    end
    need_q_c = (mode_c == MODE_SPLIT) && (len_c > frac_c);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_c;
      len_q    <= len_c;
      frac_q   <= frac_c;
      ilen_q   <= len_c - frac_c;
      total_q  <= total_c;
      need_q_q <= need_q_c;
    end
    if (capture_v) begin
      vbcd_q <= bcd_res;
    end
  end

  // The converter first takes the value itself, then the quotient if it is printed.
  assign bcd_bin = accept ? in_data_i.value : quotient;

  dfpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (in_data_i.value),
    .divisor_i  (in_data_i.point_divisor),
    .quotient_o (quotient),
    .sts_o      (div_sts)
  );

  dfpf_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .bin_i   (bcd_bin),
    .bcd_o   (bcd_res),
    .sts_o   (bcd_sts)
  );

  // Character at output position k_q. Value digits come from vbcd_q; quotient digits
  // are read straight from the converter, which holds them until the next item.
  always_comb begin
    pos              = '0;
    digit            = get_digit(vbcd_q, pos);
    char_c.char_code = CH_ZERO;
    case (mode_q)
      MODE_PLAIN: begin
        pos              = len_q - k_q - CNT_W'(1);
        digit            = get_digit(vbcd_q, pos);
        char_c.char_code = CH_ZERO + CHAR_W'(digit);
      end
      MODE_LEAD: begin
        // A point, zeros up to the digit count, then the value's digits.
        pos   = frac_q - k_q;
        digit = get_digit(vbcd_q, pos);
        if (k_q == '0) begin
          char_c.char_code = CH_POINT;
        end else if (pos >= len_q) begin
          char_c.char_code = CH_ZERO;
        end else begin
          char_c.char_code = CH_ZERO + CHAR_W'(digit);
        end
      end
      MODE_SPLIT: begin
        if (k_q < ilen_q) begin
          pos              = ilen_q - k_q - CNT_W'(1);
          digit            = get_digit(bcd_res, pos);
          char_c.char_code = CH_ZERO + CHAR_W'(digit);
        end else if (k_q == ilen_q) begin
          char_c.char_code = CH_POINT;
        end else begin
          pos              = len_q - k_q;
          digit            = get_digit(vbcd_q, pos);
          char_c.char_code = CH_ZERO + CHAR_W'(digit);
        end
      end
      default: begin
        char_c.char_code = CH_ZERO;
      end
    endcase
    char_c.last_char = (k_q == total_q - CNT_W'(1));
  end

  // Sequencer: wait for the units, optionally convert the quotient, then print.
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    capture_v = 1'b0;
    bcd_start = accept;
    emit_fire = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          k_d     = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_sts.done) begin
          capture_v = 1'b1;
          if (need_q_q) begin
            bcd_start = 1'b1;
            state_d   = ST_CONVQ;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_CONVQ: begin
        if (bcd_sts.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit_fire = !out_valid_q || out_ready_i;
        if (emit_fire) begin
          k_d = k_q + CNT_W'(1);
          if (char_c.last_char) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_data_q <= char_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The divider and the converter start together and must finish together.
  a_units_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && bcd_sts.done) |-> div_sts.done)
    else $error("divider and converter out of step");

  // No unit may still be running when a new item can be taken.
  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!bcd_sts.busy && !div_sts.busy))
    else $error("unit busy while idle");

  // The character index never runs past the end of the string.
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (k_q < total_q))
    else $error("character index past end of string");

  // Emitting the final character returns the sequencer to idle.
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && char_c.last_char) |=> (state_q == ST_IDLE))
    else $error("sequencer did not finish after last character");

endmodule

[hw/rtl/dfpf_div.sv]
module dfpf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dfpf_pkg::DATA_W-1:0] dividend_i,
  input  logic [dfpf_pkg::DIV_W-1:0]  divisor_i,
  output logic [dfpf_pkg::DATA_W-1:0] quotient_o,
  output dfpf_pkg::dfpf_sts_t         sts_o
);
  import dfpf_pkg::*;

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]  div_q;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              ge;

  // Restoring division, one quotient bit per cycle. A zero divisor yields all ones.
  always_comb begin
    shifted = {rem_q, dvd_q[DATA_W-1]};
    ge      = shifted >= {1'b0, div_q};
    diff    = shifted - {1'b0, div_q};
    rem_d   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    dvd_d   = {dvd_q[DATA_W-2:0], ge};
    cnt_d   = cnt_q + STEP_W'(1);
    busy_d  = busy_q && (cnt_q != STEP_W'(STEPS - 1));
    done_d  = busy_q && (cnt_q == STEP_W'(STEPS - 1));
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign quotient_o = dvd_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

[hw/rtl/dfpf_bcd.sv]
module dfpf_bcd (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dfpf_pkg::DATA_W-1:0] bin_i,
  output logic [dfpf_pkg::BCD_W-1:0]  bcd_o,
  output dfpf_pkg::dfpf_sts_t         sts_o
);
  import dfpf_pkg::*;

  logic [DATA_W-1:0] bin_q;
  logic [BCD_W-1:0]  bcd_q;
  logic [BCD_W-1:0]  adj;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  // Shift-and-add-three conversion, one input bit per cycle.
  always_comb begin
    adj    = bcd_adjust(bcd_q);
    cnt_d  = cnt_q + STEP_W'(1);
    busy_d = busy_q && (cnt_q != STEP_W'(STEPS - 1));
    done_d = busy_q && (cnt_q == STEP_W'(STEPS - 1));
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[DATA_W-2:0], 1'b0};
      bcd_q <= {adj[BCD_W-2:0], bin_q[DATA_W-1]};
    end
  end

  assign bcd_o      = bcd_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import dfpf_pkg::*;

  // The cmd field selects between the two output formats.
  localparam logic CMD_PLAIN = 1'b0;
  localparam logic CMD_FIXED = 1'b1;

  // The slowest item runs two conversion passes plus eleven characters, each of which can
  // wait out a long receiver stall, plus the longest sender gap. Several times that over all
  // items still stays far below this limit.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Quiet cycles after the last expected character, enough for two conversion passes.
  localparam int unsigned DRAIN_CYCLES = 100;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  dfpf_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  dfpf_out_t out_data_o;

  // Characters still owed by the block, oldest first.
  dfpf_out_t         exp_chars[$];
  // Scratch line built by the formatter model for one item.
  logic [CHAR_W-1:0] line_chars[MAX_DIGITS + 2];
  int unsigned       line_len;

  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned items_sent    = 0;
  int unsigned chars_checked = 0;
  int unsigned n_fail        = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  decimal_fixed_point_formatter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------------------------
  // Formatter model. Each accepted item is turned into its full character line here, and
  // the characters are queued with the final one flagged.
  // ---------------------------------------------------------------------------------------

  // Decimal digit of v at position pos, where position zero is the units digit.
  function automatic logic [3:0] dec_digit(logic [63:0] v, int unsigned pos);
    logic [63:0] r;
    r = v;
    for (int unsigned i = 0; i < pos; i++) begin
      r = r / 64'd10;
    end
    return 4'(r % 64'd10);
  endfunction

  function automatic void add_char(logic [CHAR_W-1:0] c);
    line_chars[line_len] = c;
    line_len++;
  endfunction

  // Appends the low n digits of v, most significant first, zero-padded.
  function automatic void add_digits(logic [63:0] v, int unsigned n);
    for (int i = int'(n); i >= 1; i--) begin
      add_char(CH_ZERO + CHAR_W'(dec_digit(v, i - 1)));
    end
  endfunction

  function automatic void predict_chars(dfpf_in_t it);
    int unsigned len;
    int unsigned frac;
    logic [63:0] quot;
    dfpf_out_t   o;
    len      = 32'(it.digit_count);
    frac     = 32'(it.frac_digits);
    line_len = 0;
    // A zero digit count means one digit; both counts saturate at the maximum.
    if (len == 0) begin
      len = 1;
    end
    if (len > MAX_DIGITS) begin
      len = MAX_DIGITS;
    end
    if (frac > MAX_DIGITS) begin
      frac = MAX_DIGITS;
    end
    if (it.cmd == CMD_PLAIN) begin
      add_digits(64'(it.value), len);
    end else if (len < frac) begin
      // Pure fraction: the point, the padding zeros, then the digits themselves.
      add_char(CH_POINT);
      for (int unsigned z = 0; z < frac - len; z++) begin
        add_char(CH_ZERO);
      end
      add_digits(64'(it.value), len);
    end else begin
      // Integer part comes from the quotient; a zero divisor yields all ones.
      if (it.point_divisor == '0) begin
        quot = 64'hFFFF_FFFF;
      end else begin
        quot = 64'(it.value) / 64'(it.point_divisor);
      end
      if (len > frac) begin
        add_digits(quot, len - frac);
      end
      add_char(CH_POINT);
      add_digits(64'(it.value), frac);
    end
    for (int unsigned k = 0; k < line_len; k++) begin
      o.char_code = line_chars[k];
      o.last_char = (k == line_len - 1);
      exp_chars.push_back(o);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Scoreboard. Outputs and inputs are both sampled at the rising edge, before the block
  // updates, so every handshake is seen exactly once with its pre-edge values.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dfpf_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (exp_chars.size() == 0) begin
          $error("char_code: no character expected, got %h", out_data_o.char_code);
          n_fail++;
        end else begin
          want = exp_chars.pop_front();
          chars_checked++;
          if (out_data_o.char_code !== want.char_code) begin
            $error("char_code: expected %h, got %h", want.char_code, out_data_o.char_code);
            n_fail++;
          end
          if (out_data_o.last_char !== want.last_char) begin
            $error("last_char: expected %b, got %b", want.last_char, out_data_o.last_char);
            n_fail++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_chars(in_data_i);
        items_sent++;
      end
    end
  end

  // The receiver stalls at random; the chance is set per test phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("decimal_fixed_point_formatter_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  function automatic dfpf_in_t make_item(logic cmd, logic [DATA_W-1:0] value,
                                         int unsigned len, int unsigned frac,
                                         logic [DIV_W-1:0] div);
    dfpf_in_t it;
    it.cmd           = cmd;
    it.value         = value;
    it.digit_count   = LEN_W'(len);
    it.frac_digits   = LEN_W'(frac);
    it.point_divisor = div;
    return it;
  endfunction

  function automatic logic [DIV_W-1:0] pow10(int unsigned n);
    logic [DIV_W-1:0] p;
    p = DIV_W'(1);
    // Ten to the tenth does not fit the divisor field, so stop at the ninth power.
    for (int unsigned i = 0; i < n && i < 9; i++) begin
      p = p * DIV_W'(10);
    end
    return p;
  endfunction

  // Called at a rising edge. Holds valid and the payload until the item is taken, then
  // may drop valid for a random gap. Valid stays high when the next item follows at once.
  task automatic send_item(input dfpf_in_t it);
    int unsigned gap;
    gap = 0;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      // Gaps up to the length of a full two-pass conversion land on every phase of it.
      gap = $urandom_range(1, 70);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random items lean toward meaningful fixed-point setups: divisors that match the
  // fraction count and counts in range, with a share of out-of-range counts and odd
  // divisors mixed in.
  function automatic dfpf_in_t random_item();
    dfpf_in_t    it;
    int unsigned frac_eff;
    it.cmd = ($urandom_range(0, 3) == 0) ? CMD_PLAIN : CMD_FIXED;
    case ($urandom_range(0, 3))
      0:       it.value = $urandom;
      1:       it.value = $urandom_range(0, 99999);
      2:       it.value = $urandom >> $urandom_range(0, 31);
      default: it.value = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      it.digit_count = LEN_W'($urandom_range(0, 15));
    end else begin
      it.digit_count = LEN_W'($urandom_range(1, MAX_DIGITS));
    end
    if ($urandom_range(0, 9) == 0) begin
      it.frac_digits = LEN_W'($urandom_range(0, 15));
    end else begin
      it.frac_digits = LEN_W'($urandom_range(0, MAX_DIGITS));
    end
    frac_eff = 32'(it.frac_digits);
    case ($urandom_range(0, 9))
      6, 7:    it.point_divisor = DIV_W'($urandom);
      8:       it.point_divisor = DIV_W'($urandom_range(0, 16));
      9:       it.point_divisor = ($urandom_range(0, 1) == 0) ? '0 : '1;
      default: it.point_divisor = pow10(frac_eff);
    endcase
    return it;
  endfunction

  // Plain mode: both ends of the value range, all ten digits, and a full-width fraction
  // count and divisor that must be ignored.
  task automatic test_plain_digits();
    send_item(make_item(CMD_PLAIN, 32'd0, 1, 0, 30'd1));
    send_item(make_item(CMD_PLAIN, 32'hFFFF_FFFF, 10, 0, 30'd1));
    send_item(make_item(CMD_PLAIN, 32'd1234567890, 10, 15, '1));
    send_item(make_item(CMD_PLAIN, 32'd987654321, 4, 9, 30'd0));
    send_item(make_item(CMD_PLAIN, 32'd7, 6, 3, 30'd1000));
  endtask

  // Fixed point: integer and fraction split, pure fraction with padding zeros, equal
  // counts, and a zero fraction count that ends on the point.
  task automatic test_fixed_point();
    send_item(make_item(CMD_FIXED, 32'd12345, 8, 3, 30'd1000));
    send_item(make_item(CMD_FIXED, 32'd7, 2, 5, 30'd100000));
    send_item(make_item(CMD_FIXED, 32'd123, 4, 4, 30'd10000));
    send_item(make_item(CMD_FIXED, 32'd99, 3, 0, 30'd1));
    send_item(make_item(CMD_FIXED, 32'hFFFF_FFFF, 10, 9, 30'd1000000000));
    send_item(make_item(CMD_FIXED, 32'd4294967, 10, 1, 30'd10));
    send_item(make_item(CMD_FIXED, 32'd0, 1, 9, 30'd1000000000));
  endtask

  // Count saturation, zero counts, zero and all-ones divisors.
  task automatic test_limits();
    send_item(make_item(CMD_PLAIN, 32'd42, 0, 0, 30'd1));
    send_item(make_item(CMD_PLAIN, 32'hFFFF_FFFF, 15, 15, '1));
    send_item(make_item(CMD_FIXED, 32'd5, 10, 1, 30'd0));
    send_item(make_item(CMD_FIXED, 32'hFFFF_FFFF, 12, 15, '1));
    send_item(make_item(CMD_FIXED, 32'd321, 3, 15, 30'd1));
    send_item(make_item(CMD_FIXED, 32'd8, 0, 0, 30'd0));
    send_item(make_item(CMD_FIXED, 32'hFFFF_FFFF, 15, 2, '1));
    send_item(make_item(CMD_FIXED, 32'd3000000000, 15, 0, 30'd3));
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned snd, int unsigned rcv);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    for (int unsigned i = 0; i < n; i++) begin
      send_item(random_item());
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_digits();
    test_fixed_point();
    test_limits();
    test_random_traffic(80, 0, 0);
    test_random_traffic(80, 66, 0);
    test_random_traffic(80, 0, 66);
    test_random_traffic(80, 14, 14);

    // Let the last accepted item reach the scoreboard, then drain.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (exp_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (exp_chars.size() != 0) begin
      $error("char_code: %0d characters never arrived", exp_chars.size());
      n_fail++;
    end

    $display("Checked %0d characters from %0d items in plain and fixed-point formats,",
             chars_checked, items_sent);
    $display("including count saturation, zero divisors and four sender/receiver idle mixes.");
    if (n_fail == 0) begin
      $display("decimal_fixed_point_formatter_top test passed");
    end else begin
      $display("decimal_fixed_point_formatter_top test failed");
    end
    $finish;
  end

endmodule
